// File: rtl/qrot_pkg.sv
// Shared types and constants for the quad/rectangle overlap test pipeline.
`default_nettype none

package qrot_pkg;

   localparam int CoordW    = 14;              // width of every input coordinate
   localparam int DiffW     = CoordW + 1;      // coordinate difference
   localparam int ProdW     = 2 * DiffW;       // product of two differences
   localparam int SumW      = ProdW + 1;       // product plus divisor
   localparam int NumCorner = 4;               // corners of rectangle and quad
   localparam int NumTest   = NumCorner * NumCorner;  // corner x edge pairs

   // One input word as captured from the request channel
   typedef struct packed {
      logic [CoordW-1:0]                    rect_left;
      logic [CoordW-1:0]                    rect_top;
      logic [CoordW-1:0]                    rect_right;
      logic [CoordW-1:0]                    rect_bottom;
      logic [NumCorner-1:0][CoordW-1:0]     qx;
      logic [NumCorner-1:0][CoordW-1:0]     qy;
   } item_type;

   // Per corner/edge operands, divisor already made positive
   typedef struct packed {
      logic                    straddle;   // exactly one edge end above the corner
      logic signed [DiffW-1:0] dxn;        // edge dx, sign follows dy normalization
      logic signed [DiffW-1:0] dyv;        // corner y minus edge start y
      logic [CoordW-1:0]       dpos;       // |edge dy|
      logic signed [DiffW-1:0] tdiff;      // corner x minus edge start x
   } setup_type;

   typedef struct packed {
      setup_type [NumTest-1:0] test;
      logic [NumCorner-1:0]    contain;    // quad corner inside the rectangle
   } setup_word_type;

   // Products ready for the crossing decision
   typedef struct packed {
      logic                    straddle;
      logic signed [ProdW-1:0] num;        // dxn * dyv
      logic signed [ProdW-1:0] prod;       // tdiff * dpos
      logic [CoordW-1:0]       dpos;
   } mul_type;

   typedef struct packed {
      mul_type [NumTest-1:0] test;
      logic [NumCorner-1:0]  contain;
   } mul_word_type;

endpackage

`default_nettype wire

// File: rtl/qrot_setup_stage.sv
// Pipeline stage 1: edge differences, straddle flags and containment compares.
`default_nettype none

module qrot_setup_stage
   import qrot_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire item_type        in_item,
   output      logic            in_ready,
   output      logic            out_valid,
   input  wire logic            out_ready,
   output      setup_word_type  out_word
);

   setup_type            test_w [NumTest];
   logic [NumCorner-1:0] contain_w;
   setup_word_type       word_in;
   setup_word_type       word_ff;
   logic                 valid_ff;

   // Rectangle corners in order TL, TR, BR, BL against each quad edge
   for (genvar gc = 0; gc < NumCorner; gc++) begin : g_corner
      logic signed [CoordW-1:0] px;
      logic signed [CoordW-1:0] py;

      assign px = (gc == 1 || gc == 2) ? $signed(in_item.rect_right)
                                       : $signed(in_item.rect_left);
      assign py = (gc >= 2) ? $signed(in_item.rect_bottom) : $signed(in_item.rect_top);

      for (genvar ge = 0; ge < NumCorner; ge++) begin : g_edge
         localparam int Nxt = (ge + 1) % NumCorner;
         logic signed [CoordW-1:0] x1, y1, x2, y2;
         logic signed [DiffW-1:0]  dx, dy, dyv, tdiff;
         logic                     neg;

         assign x1    = $signed(in_item.qx[ge]);
         assign y1    = $signed(in_item.qy[ge]);
         assign x2    = $signed(in_item.qx[Nxt]);
         assign y2    = $signed(in_item.qy[Nxt]);
         assign dx    = DiffW'(x2) - DiffW'(x1);
         assign dy    = DiffW'(y2) - DiffW'(y1);
         assign dyv   = DiffW'(py) - DiffW'(y1);
         assign tdiff = DiffW'(px) - DiffW'(x1);
         assign neg   = dy[DiffW-1];

         // flip numerator and divisor together so the divisor is positive
         assign test_w[gc*NumCorner + ge] = '{
            straddle: ((y1 > py) != (y2 > py)),
            dxn:      (neg ? -dx : dx),
            dyv:      dyv,
            dpos:     (neg ? CoordW'(-dy) : CoordW'(dy)),
            tdiff:    tdiff
         };
      end
   end

   // Quad corner inside rectangle, bounds inclusive
   for (genvar gq = 0; gq < NumCorner; gq++) begin : g_contain
      assign contain_w[gq] =
         ($signed(in_item.qx[gq]) >= $signed(in_item.rect_left))  &&
         ($signed(in_item.qx[gq]) <= $signed(in_item.rect_right)) &&
         ($signed(in_item.qy[gq]) >= $signed(in_item.rect_top))   &&
         ($signed(in_item.qy[gq]) <= $signed(in_item.rect_bottom));
   end

   always_comb begin
      for (int k = 0; k < NumTest; k++) begin
         word_in.test[k] = test_w[k];
      end
      word_in.contain = contain_w;
   end

   // Stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// File: rtl/qrot_mul_stage.sv
// Pipeline stage 2: the two products of every corner/edge crossing test.
`default_nettype none

module qrot_mul_stage
   import qrot_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire setup_word_type  in_word,
   output      logic            in_ready,
   output      logic            out_valid,
   input  wire logic            out_ready,
   output      mul_word_type    out_word
);

   mul_word_type word_in;
   mul_word_type word_ff;
   logic         valid_ff;

   // Divide-free form: compare tdiff*d against dx*(py-y1)
   always_comb begin
      for (int k = 0; k < NumTest; k++) begin
         word_in.test[k].straddle = in_word.test[k].straddle;
         word_in.test[k].num  = ProdW'(in_word.test[k].dxn) * ProdW'(in_word.test[k].dyv);
         word_in.test[k].prod = ProdW'(in_word.test[k].tdiff)
                                * $signed({{(ProdW-CoordW){1'b0}}, in_word.test[k].dpos});
         word_in.test[k].dpos = in_word.test[k].dpos;
      end
      word_in.contain = in_word.contain;
   end

   // Stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// File: rtl/qrot_decide_stage.sv
// Pipeline stage 3: crossing decisions, even-odd parity and the output register.
`default_nettype none

module qrot_decide_stage
   import qrot_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          active,
   input  wire logic          in_valid,
   input  wire mul_word_type  in_word,
   output      logic          in_ready,
   output      logic          out_valid,
   input  wire logic          out_ready,
   output      logic          out_hit
);

   logic [NumTest-1:0]   cross_w;
   logic [NumCorner-1:0] inside_w;
   logic                 hit_in;
   logic                 hit_ff;
   logic                 valid_ff;

   // px < trunc(N/d) + x1 with d > 0:
   //   N >= 0: (t+1)*d <= N      N < 0: t*d < N
   always_comb begin
      for (int k = 0; k < NumTest; k++) begin
         logic signed [SumW-1:0] lhs;
         logic signed [SumW-1:0] rhs;
         lhs = SumW'(in_word.test[k].prod)
               + $signed({{(SumW-CoordW){1'b0}}, in_word.test[k].dpos});
         rhs = SumW'(in_word.test[k].num);
         if (in_word.test[k].num[ProdW-1]) begin
            cross_w[k] = in_word.test[k].straddle
                         && (in_word.test[k].prod < in_word.test[k].num);
         end else begin
            cross_w[k] = in_word.test[k].straddle && (lhs <= rhs);
         end
      end
      for (int c = 0; c < NumCorner; c++) begin
         inside_w[c] = ^cross_w[c*NumCorner +: NumCorner];
      end
      hit_in = active && ((|inside_w) || (|in_word.contain));
   end

   // Output register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         hit_ff <= hit_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;

endmodule

`default_nettype wire

// File: rtl/quad_rect_overlap_test_top.sv
// An accepted word passes the input, setup, multiply and decide registers in order to rsp_valid.
// Throughput: one word per cycle while rsp_stall is low; four register stages.
// Each stage holds its word under rsp_stall and takes a new one as soon as it empties.
// Reset (synchronous, active high) empties the pipeline and clears hitbox_active to 0.
// Only the four stage valid bits and the enable register are reset.
`default_nettype none

module quad_rect_overlap_test_top
   import qrot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // configuration
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data,
   // request channel
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [CoordW-1:0] req_rect_left,
   input  wire logic [CoordW-1:0] req_rect_top,
   input  wire logic [CoordW-1:0] req_rect_right,
   input  wire logic [CoordW-1:0] req_rect_bottom,
   input  wire logic [CoordW-1:0] req_quad_x0,
   input  wire logic [CoordW-1:0] req_quad_y0,
   input  wire logic [CoordW-1:0] req_quad_x1,
   input  wire logic [CoordW-1:0] req_quad_y1,
   input  wire logic [CoordW-1:0] req_quad_x2,
   input  wire logic [CoordW-1:0] req_quad_y2,
   input  wire logic [CoordW-1:0] req_quad_x3,
   input  wire logic [CoordW-1:0] req_quad_y3,
   // response channel
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_overlap_hit
);

   logic           hitbox_active_ff;
   logic           in_valid_ff;
   item_type       item_in;
   item_type       item_ff;
   logic           in_ready;
   logic           setup_ready;
   logic           setup_valid;
   setup_word_type setup_word;
   logic           mul_ready;
   logic           mul_valid;
   mul_word_type   mul_word;
   logic           decide_ready;

   // Enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         hitbox_active_ff <= 1'b0;
      end else if (csr_wr_en) begin
         hitbox_active_ff <= csr_wr_data;
      end
   end

   // Input register
   always_comb begin
      item_in.rect_left   = req_rect_left;
      item_in.rect_top    = req_rect_top;
      item_in.rect_right  = req_rect_right;
      item_in.rect_bottom = req_rect_bottom;
      item_in.qx[0]       = req_quad_x0;
      item_in.qy[0]       = req_quad_y0;
      item_in.qx[1]       = req_quad_x1;
      item_in.qy[1]       = req_quad_y1;
      item_in.qx[2]       = req_quad_x2;
      item_in.qy[2]       = req_quad_y2;
      item_in.qx[3]       = req_quad_x3;
      item_in.qy[3]       = req_quad_y3;
   end

   assign in_ready  = !in_valid_ff || setup_ready;
   assign req_stall = !in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
      if (in_ready && req_valid) begin
         item_ff <= item_in;
      end
   end

   qrot_setup_stage u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_item   (item_ff),
      .in_ready  (setup_ready),
      .out_valid (setup_valid),
      .out_ready (mul_ready),
      .out_word  (setup_word)
   );

   qrot_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_valid),
      .in_word   (setup_word),
      .in_ready  (mul_ready),
      .out_valid (mul_valid),
      .out_ready (decide_ready),
      .out_word  (mul_word)
   );

   qrot_decide_stage u_decide (
      .clock     (clock),
      .reset     (reset),
      .active    (hitbox_active_ff),
      .in_valid  (mul_valid),
      .in_word   (mul_word),
      .in_ready  (decide_ready),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_hit   (rsp_overlap_hit)
   );

endmodule

`default_nettype wire
